// File: sv/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and fixed constants of the triangle plane slicer.
// ----------------------------------------------------------------------------
`default_nettype none
package tps_pkg;
   // width of the saturating coplanar fault count
   localparam int FAULT_WIDTH = 16;

   // fraction bits of a coordinate; the cut ratio has no unit, so the
   // arithmetic does not depend on it
   localparam int FRAC_BITS = 16;

   // vertex position relative to the slicing plane
   typedef enum logic [1:0] {
      SIDE_ON    = 2'd0,
      SIDE_ABOVE = 2'd1,
      SIDE_BELOW = 2'd2
   } side_type;

   // vertex selectors
   localparam logic [1:0] VERT_A = 2'd0;
   localparam logic [1:0] VERT_B = 2'd1;
   localparam logic [1:0] VERT_C = 2'd2;
endpackage
`default_nettype wire

// File: sv/triangle_plane_slicer.sv
// ----------------------------------------------------------------------------
// triangle_plane_slicer
// Cuts one triangle with a horizontal plane and returns the segment ends.
// ----------------------------------------------------------------------------
// One triangle enters per cycle while the pipeline advances; its result
// reaches the result port after an input register, a classify stage, a
// multiply stage, a restoring divider with one quotient bit per stage
// (COORD_WIDTH stages), and the output register. The whole pipeline
// advances together whenever the output register is empty or its result
// is being taken, so throughput is one triangle per cycle while the
// consumer keeps up. Edges crossing the plane are cut as
// P + (Q - P) * (h - Pz) / (Qz - Pz), truncated toward zero.
// A triangle lying wholly in the plane reports a fault and bumps a
// saturating counter that is sent with every result.
`default_nettype none
module triangle_plane_slicer #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_vert_a_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_vert_a_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_vert_a_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_vert_b_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_vert_b_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_vert_b_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_vert_c_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_vert_c_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_vert_c_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_plane_height,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_hit,
   output logic signed [COORD_WIDTH-1:0]      rsp_start_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_start_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_end_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_end_y,
   output logic                               rsp_coplanar_fault,
   output logic [tps_pkg::FAULT_WIDTH-1:0]    rsp_fault_total
);
   import tps_pkg::*;

   localparam int W = COORD_WIDTH;

   typedef logic signed [W-1:0] coord_type;

   typedef struct packed {
      coord_type [2:0]        vx;
      coord_type [2:0]        vy;
      coord_type [2:0]        vz;
      coord_type              h;
      logic                   fault;
      logic [FAULT_WIDTH-1:0] total;
   } tri_type;

   typedef struct packed {
      coord_type       base;
      logic            neg;
      logic [W-1:0]    mdv;
      logic [W-1:0]    mnum;
      logic [W-1:0]    den;
      logic [2*W-1:0]  rem;
      logic [W-1:0]    quo;
   } lane_type;

   typedef struct packed {
      logic                   hit;
      logic                   fault;
      logic [FAULT_WIDTH-1:0] total;
      logic                   s_dir;
      logic                   e_dir;
      coord_type              sx;
      coord_type              sy;
      coord_type              ex;
      coord_type              ey;
      lane_type [3:0]         lane;
   } item_type;

   // build one cut lane from the endpoint coordinates
   function automatic lane_type make_lane(coord_type pp, coord_type qp, coord_type pz,
                                          coord_type qz, coord_type hh);
      lane_type         l;
      logic signed [W:0] dv;
      logic signed [W:0] num;
      logic signed [W:0] den;
      logic signed [W:0] adv;
      logic signed [W:0] anum;
      logic signed [W:0] aden;
      dv   = {qp[W-1], qp} - {pp[W-1], pp};
      num  = {hh[W-1], hh} - {pz[W-1], pz};
      den  = {qz[W-1], qz} - {pz[W-1], pz};
      adv  = dv[W] ? -dv : dv;
      anum = num[W] ? -num : num;
      aden = den[W] ? -den : den;
      l      = '0;
      l.base = pp;
      l.neg  = dv[W] ^ (num[W] ^ den[W]);
      l.mdv  = adv[W-1:0];
      l.mnum = anum[W-1:0];
      l.den  = aden[W-1:0];
      return l;
   endfunction

   // pipeline advance
   logic adv_en;
   logic rsp_valid_ff;
   assign adv_en    = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv_en;

   // fault counter, updated in input order
   logic [FAULT_WIDTH-1:0] fault_cnt_ff;
   logic [FAULT_WIDTH-1:0] fault_cnt_in;
   logic                   in_fault;

   assign in_fault = (req_vert_a_z == req_plane_height) &&
                     (req_vert_b_z == req_plane_height) &&
                     (req_vert_c_z == req_plane_height);

   always_comb begin
      fault_cnt_in = fault_cnt_ff;
      if (req_valid && adv_en && in_fault && (fault_cnt_ff != {FAULT_WIDTH{1'b1}})) begin
         fault_cnt_in = fault_cnt_ff + FAULT_WIDTH'(1);
      end
   end

   // input stage
   logic    a_vld_ff;
   tri_type a_ff;
   tri_type a_in;

   always_comb begin
      a_in.vx    = {req_vert_c_x, req_vert_b_x, req_vert_a_x};
      a_in.vy    = {req_vert_c_y, req_vert_b_y, req_vert_a_y};
      a_in.vz    = {req_vert_c_z, req_vert_b_z, req_vert_a_z};
      a_in.h     = req_plane_height;
      a_in.fault = in_fault;
      a_in.total = fault_cnt_in;
   end

   // classify stage
   side_type [2:0] sd;
   logic     [1:0] p1;
   logic     [1:0] q1;
   logic     [1:0] p2;
   logic     [1:0] q2;
   logic     [1:0] ds;
   logic     [1:0] de;
   logic           b_vld_ff;
   item_type       b_ff;
   item_type       b_in;

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         if (a_ff.vz[v] > a_ff.h) begin
            sd[v] = SIDE_ABOVE;
         end else if (a_ff.vz[v] < a_ff.h) begin
            sd[v] = SIDE_BELOW;
         end else begin
            sd[v] = SIDE_ON;
         end
      end
   end

   always_comb begin
      b_in       = '0;
      b_in.fault = a_ff.fault;
      b_in.total = a_ff.total;
      p1 = VERT_A; q1 = VERT_C; p2 = VERT_B; q2 = VERT_C;
      ds = VERT_A; de = VERT_B;
      priority if ((sd[0] == SIDE_ABOVE && sd[1] == SIDE_ABOVE && sd[2] == SIDE_ABOVE) ||
                   (sd[0] == SIDE_BELOW && sd[1] == SIDE_BELOW && sd[2] == SIDE_BELOW)) begin
         b_in.hit = 1'b0;
      end else if (sd[0] == SIDE_ON && sd[1] == SIDE_ON && sd[2] == SIDE_ON) begin
         b_in.hit = 1'b0;
      end else if (sd[0] == SIDE_ON && sd[1] == SIDE_ON) begin
         b_in.hit = 1'b1; b_in.s_dir = 1'b1; b_in.e_dir = 1'b1;
         ds = VERT_A; de = VERT_B;
      end else if (sd[0] == SIDE_ON && sd[2] == SIDE_ON) begin
         b_in.hit = 1'b1; b_in.s_dir = 1'b1; b_in.e_dir = 1'b1;
         ds = VERT_A; de = VERT_C;
      end else if (sd[1] == SIDE_ON && sd[2] == SIDE_ON) begin
         b_in.hit = 1'b1; b_in.s_dir = 1'b1; b_in.e_dir = 1'b1;
         ds = VERT_B; de = VERT_C;
      end else if (sd[0] == SIDE_ON) begin
         b_in.hit = (sd[1] != sd[2]); b_in.s_dir = 1'b1;
         ds = VERT_A; p2 = VERT_B; q2 = VERT_C;
      end else if (sd[1] == SIDE_ON) begin
         b_in.hit = (sd[0] != sd[2]); b_in.s_dir = 1'b1;
         ds = VERT_B; p2 = VERT_A; q2 = VERT_C;
      end else if (sd[2] == SIDE_ON) begin
         b_in.hit = (sd[0] != sd[1]); b_in.s_dir = 1'b1;
         ds = VERT_C; p2 = VERT_A; q2 = VERT_B;
      end else if (sd[0] == sd[1]) begin
         b_in.hit = 1'b1;
         p1 = VERT_A; q1 = VERT_C; p2 = VERT_B; q2 = VERT_C;
      end else if (sd[1] == sd[2]) begin
         b_in.hit = 1'b1;
         p1 = VERT_B; q1 = VERT_A; p2 = VERT_C; q2 = VERT_A;
      end else begin
         b_in.hit = 1'b1;
         p1 = VERT_B; q1 = VERT_C; p2 = VERT_B; q2 = VERT_A;
      end
      b_in.sx = a_ff.vx[ds];
      b_in.sy = a_ff.vy[ds];
      b_in.ex = a_ff.vx[de];
      b_in.ey = a_ff.vy[de];
      b_in.lane[0] = make_lane(a_ff.vx[p1], a_ff.vx[q1], a_ff.vz[p1], a_ff.vz[q1], a_ff.h);
      b_in.lane[1] = make_lane(a_ff.vy[p1], a_ff.vy[q1], a_ff.vz[p1], a_ff.vz[q1], a_ff.h);
      b_in.lane[2] = make_lane(a_ff.vx[p2], a_ff.vx[q2], a_ff.vz[p2], a_ff.vz[q2], a_ff.h);
      b_in.lane[3] = make_lane(a_ff.vy[p2], a_ff.vy[q2], a_ff.vz[p2], a_ff.vz[q2], a_ff.h);
   end

   // multiply stage
   logic     c_vld_ff;
   item_type c_ff;
   item_type c_in;

   always_comb begin
      c_in = b_ff;
      for (int k = 0; k < 4; k++) begin
         c_in.lane[k].rem = {{W{1'b0}}, b_ff.lane[k].mdv} * {{W{1'b0}}, b_ff.lane[k].mnum};
         c_in.lane[k].quo = '0;
      end
   end

   // divider stages, one quotient bit each, most significant first
   logic     [W-1:0] d_vld_ff;
   item_type [W-1:0] d_ff;
   item_type [W-1:0] d_in;
   item_type [W-1:0] d_src;

   always_comb begin
      d_src[0] = c_ff;
      for (int s = 0; s < W - 1; s++) begin
         d_src[s+1] = d_ff[s];
      end
   end

   always_comb begin
      logic [2*W-1:0] sh;
      sh = '0;
      for (int s = 0; s < W; s++) begin
         d_in[s] = d_src[s];
         for (int k = 0; k < 4; k++) begin
            sh = {{W{1'b0}}, d_src[s].lane[k].den} << (W - 1 - s);
            if (d_src[s].lane[k].rem >= sh) begin
               d_in[s].lane[k].rem = d_src[s].lane[k].rem - sh;
               d_in[s].lane[k].quo[W-1-s] = 1'b1;
            end
         end
      end
   end

   // output stage: apply sign, add base point, pick direct vertices
   item_type  fin;
   coord_type cut_v [4];
   coord_type rsp_start_x_in;
   coord_type rsp_start_y_in;
   coord_type rsp_end_x_in;
   coord_type rsp_end_y_in;

   assign fin = d_ff[W-1];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cut_v[k] = fin.lane[k].base +
                    (fin.lane[k].neg ? coord_type'(-fin.lane[k].quo)
                                     : coord_type'(fin.lane[k].quo));
      end
      rsp_start_x_in = '0;
      rsp_start_y_in = '0;
      rsp_end_x_in   = '0;
      rsp_end_y_in   = '0;
      if (fin.hit) begin
         rsp_start_x_in = fin.s_dir ? fin.sx : cut_v[0];
         rsp_start_y_in = fin.s_dir ? fin.sy : cut_v[1];
         rsp_end_x_in   = fin.e_dir ? fin.ex : cut_v[2];
         rsp_end_y_in   = fin.e_dir ? fin.ey : cut_v[3];
      end
   end

   logic                   rsp_hit_ff;
   logic                   rsp_fault_ff;
   logic [FAULT_WIDTH-1:0] rsp_total_ff;
   coord_type              rsp_start_x_ff;
   coord_type              rsp_start_y_ff;
   coord_type              rsp_end_x_ff;
   coord_type              rsp_end_y_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fault_cnt_ff <= '0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fault_cnt_ff <= fault_cnt_in;
         if (adv_en) begin
            a_vld_ff     <= req_valid;
            b_vld_ff     <= a_vld_ff;
            c_vld_ff     <= b_vld_ff;
            d_vld_ff     <= {d_vld_ff[W-2:0], c_vld_ff};
            rsp_valid_ff <= d_vld_ff[W-1];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv_en) begin
         a_ff           <= a_in;
         b_ff           <= b_in;
         c_ff           <= c_in;
         d_ff           <= d_in;
         rsp_hit_ff     <= fin.hit;
         rsp_fault_ff   <= fin.fault;
         rsp_total_ff   <= fin.total;
         rsp_start_x_ff <= rsp_start_x_in;
         rsp_start_y_ff <= rsp_start_y_in;
         rsp_end_x_ff   <= rsp_end_x_in;
         rsp_end_y_ff   <= rsp_end_y_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_coplanar_fault = rsp_fault_ff;
   assign rsp_fault_total    = rsp_total_ff;
   assign rsp_start_x        = rsp_start_x_ff;
   assign rsp_start_y        = rsp_start_y_ff;
   assign rsp_end_x          = rsp_end_x_ff;
   assign rsp_end_y          = rsp_end_y_ff;
endmodule
`default_nettype wire

// File: sv/triangle_plane_slicer_checker.sv
// ----------------------------------------------------------------------------
// tps_checker
// Port-level checks of the triangle plane slicer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module tps_checker #(
   parameter int COORD_WIDTH = 32
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_hit,
   input wire logic [COORD_WIDTH-1:0]        rsp_start_x,
   input wire logic [COORD_WIDTH-1:0]        rsp_end_y,
   input wire logic                          rsp_coplanar_fault,
   input wire logic [tps_pkg::FAULT_WIDTH-1:0] rsp_fault_total
);
   import tps_pkg::*;

   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_x) && $stable(rsp_hit))
      else $error("stalled result changed");

   // a coplanar triangle never gives a segment
   a_fault_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coplanar_fault |-> !rsp_hit)
      else $error("fault with hit");

   // a miss carries zero coordinates
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_start_x == '0 && rsp_end_y == '0)
      else $error("miss with nonzero coordinates");

   // a fault result has already counted itself
   a_fault_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coplanar_fault |-> rsp_fault_total != '0)
      else $error("fault not counted");
endmodule

bind triangle_plane_slicer tps_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tps_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_hit(rsp_hit),
   .rsp_start_x(rsp_start_x),
   .rsp_end_y(rsp_end_y),
   .rsp_coplanar_fault(rsp_coplanar_fault),
   .rsp_fault_total(rsp_fault_total)
);
`default_nettype wire
